FILE: rtl/padded_row_zone_builder_top_macros.svh
// Assertion macros shared by the checker of the padded row zone builder.
`ifndef PADDED_ROW_ZONE_BUILDER_TOP_MACROS_SVH
`define PADDED_ROW_ZONE_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, gated off by dis.
`define PRZ_ASSERT_NOW(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |-> (cons)) \
    else $error("%m: lbl failed");

// Next-cycle implication, gated off by dis.
`define PRZ_ASSERT_NEXT(lbl, ck, dis, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (dis) (ante) |=> (cons)) \
    else $error("%m: lbl failed");

`endif

FILE: rtl/prz_pkg.sv
// Shared types and constants of the padded row zone builder.
`timescale 1ns / 1ps
package prz_pkg;

  localparam int ROW_W        = 31;
  localparam int PSUM_W       = 32;
  localparam int LANE_W       = 3;
  localparam int ZTGT_W       = 10;
  localparam int CFG_INDEX_W  = 2;
  localparam int ZONE_BLOCK_DEFAULT = 128;
  localparam int ZONE_BLOCK_MAX     = 4096;
  localparam int TARGET_W     = $clog2(5 * ZONE_BLOCK_MAX + 1);
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_NONZEROS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT      = 2'd1;

  // Lane widths.
  localparam logic [LANE_W-1:0] LANE_1 = 3'd1;
  localparam logic [LANE_W-1:0] LANE_2 = 3'd2;
  localparam logic [LANE_W-1:0] LANE_3 = 3'd3;
  localparam logic [LANE_W-1:0] LANE_4 = 3'd4;
  localparam logic [LANE_W-1:0] LANE_5 = 3'd5;

  typedef struct packed {
    logic [LANE_W-1:0]   lane;
    logic [TARGET_W-1:0] target;
    logic [ROW_W-1:0]    last_row;
    logic                busy;
  } lane_info_t;

  typedef struct packed {
    logic [ROW_W-1:0]  raw;
    logic [PSUM_W-1:0] padded;
  } row_item_t;

endpackage

FILE: rtl/prz_lane.sv
// Configuration registers and derivation of lane width, zone target and last row.
`timescale 1ns / 1ps
module prz_lane #(
  parameter int ZONE_BLOCK = prz_pkg::ZONE_BLOCK_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [prz_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prz_pkg::ROW_W-1:0]        cfg_data,
  output prz_pkg::lane_info_t              info
);
  import prz_pkg::*;

  logic [ROW_W-1:0]   tnz;
  logic [ROW_W-1:0]   rows;
  logic [1:0]         pend;
  // scaled copies of T and M, one stage ahead of the compares
  logic [ROW_W:0]     t2;
  logic [ROW_W+1:0]   m3;
  logic [ROW_W+2:0]   m5;
  logic [ROW_W+3:0]   t10;
  logic [ROW_W+4:0]   m31;
  logic [ROW_W+5:0]   m41;
  logic [ROW_W-1:0]   t1;
  logic [ROW_W-1:0]   m1;
  logic [LANE_W-1:0]  lane;
  logic [LANE_W-1:0]  lane_next;
  logic [ROW_W-1:0]   last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      tnz  <= '0;
      rows <= ROW_W'(1);
      pend <= 2'd3;
      lane <= LANE_1;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL_NONZEROS) tnz <= cfg_data;
        if (cfg_index == REG_ROW_COUNT) rows <= cfg_data;
        pend <= 2'd3;
      end else if (pend != 2'd0) begin
        pend <= pend - 2'd1;
      end
      lane <= lane_next;
    end
  end

  always_ff @(posedge clk) begin
    t1       <= tnz;
    m1       <= rows;
    t2       <= {tnz, 1'b0};
    m3       <= {2'b0, rows} + {1'b0, rows, 1'b0};
    m5       <= {3'b0, rows} + {1'b0, rows, 2'b0};
    t10      <= {1'b0, tnz, 3'b0} + {3'b0, tnz, 1'b0};
    m31      <= {rows, 5'b0} - {5'b0, rows};
    m41      <= {1'b0, rows, 5'b0} + {3'b0, rows, 3'b0} + {6'b0, rows};
    last_row <= rows - ROW_W'(1);
  end

  // Exact rounding of the mean T / M done as compares against scaled M.
  always_comb begin
    if (t1 < m1)                          lane_next = LANE_1;
    else if ({1'b0, t2} < m3)             lane_next = LANE_1;
    else if ({2'b0, t2} < m5)             lane_next = LANE_2;
    else if ({2'b0, t1} < m3)             lane_next = LANE_3;
    else if ({1'b0, t10} < m31)           lane_next = LANE_3;
    else if ({2'b0, t10} < m41)           lane_next = LANE_4;
    else                                  lane_next = LANE_5;
  end

  assign info.lane     = lane;
  assign info.target   = TARGET_W'(32'(lane) * ZONE_BLOCK);
  assign info.last_row = last_row;
  assign info.busy     = (pend != 2'd0);

endmodule

FILE: rtl/prz_front.sv
// Front end: accepts row counts and rounds each up to a multiple of the lane width.
`timescale 1ns / 1ps
module prz_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [prz_pkg::ROW_W-1:0]  row_nonzeros,
  input  prz_pkg::lane_info_t        info,
  output logic                       q_push,
  output prz_pkg::row_item_t         q_item,
  input  logic                       q_full
);
  import prz_pkg::*;

  // v mod l for v below 23 and l of 3 or 5
  function automatic logic [LANE_W-1:0] mod_small(input logic [4:0] v,
                                                  input logic [LANE_W-1:0] l);
    logic [4:0] acc;
    acc = v;
    for (int i = 0; i < 7; i++) begin
      if (acc >= {2'b0, l}) acc = acc - {2'b0, l};
    end
    return acc[LANE_W-1:0];
  endfunction

  logic             s1_valid;
  logic [ROW_W-1:0] s1_raw;
  logic [6:0]       s1_dsum;
  logic             s2_valid;
  row_item_t        s2_item;
  logic             s1_load;
  logic             s2_load;
  logic             s1_move;
  logic [6:0]       dsum;
  logic [31:0]      raw_ext;
  logic [4:0]       fold;
  logic [LANE_W-1:0] rem;
  logic [LANE_W-1:0] pad;
  logic             accept;

  assign s2_load = !s2_valid || !q_full;
  assign s1_move = s1_valid && s2_load;
  assign s1_load = !s1_valid || s1_move;
  assign full    = info.busy || !s1_load;
  assign accept  = push && !full;

  // 16 = 1 mod 3 and mod 5, so hex digits can be summed
  always_comb begin
    raw_ext = {1'b0, row_nonzeros};
    dsum    = '0;
    for (int i = 0; i < 8; i++) begin
      dsum = dsum + 7'(raw_ext[4*i +: 4]);
    end
  end

  always_comb begin
    fold = {2'b0, s1_dsum[6:4]} + {1'b0, s1_dsum[3:0]};
    case (info.lane)
      LANE_2:         rem = {2'b0, s1_raw[0]};
      LANE_4:         rem = {1'b0, s1_raw[1:0]};
      LANE_3, LANE_5: rem = mod_small(fold, info.lane);
      default:        rem = '0;
    endcase
    pad = (rem == '0) ? '0 : info.lane - rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= accept;
      if (s2_load) s2_valid <= s1_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_raw  <= row_nonzeros;
      s1_dsum <= dsum;
    end
    if (s2_load) begin
      s2_item.raw    <= s1_raw;
      s2_item.padded <= {1'b0, s1_raw} + PSUM_W'(pad);
    end
  end

  assign q_push = s2_valid;
  assign q_item = s2_item;

endmodule

FILE: rtl/prz_queue.sv
// Short queue of rounded rows between front and back.
`timescale 1ns / 1ps
module prz_queue #(
  parameter int DEPTH = prz_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  prz_pkg::row_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output prz_pkg::row_item_t  head,
  output logic                valid
);
  import prz_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  row_item_t      mem [DEPTH];
  logic [PTR_W:0] wr_ptr;
  logic [PTR_W:0] rd_ptr;
  logic           do_push;
  logic           do_pop;

  assign valid   = (wr_ptr != rd_ptr);
  assign full    = (wr_ptr[PTR_W] != rd_ptr[PTR_W]) &&
                   (wr_ptr[PTR_W-1:0] == rd_ptr[PTR_W-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr[PTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + (PTR_W+1)'(1);
      if (do_pop)  rd_ptr <= rd_ptr + (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr[PTR_W-1:0]] <= push_item;
  end

endmodule

FILE: rtl/prz_back.sv
// Back end: accumulates rounded rows and closes zones into the result register.
`timescale 1ns / 1ps
module prz_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  prz_pkg::row_item_t          q_head,
  output logic                        q_pop,
  input  prz_pkg::lane_info_t         info,
  output logic                        empty,
  input  logic                        pop,
  output logic [prz_pkg::ROW_W-1:0]   zone_first_row,
  output logic [prz_pkg::ROW_W-1:0]   zone_last_row,
  output logic [prz_pkg::ROW_W-1:0]   zone_rows,
  output logic [prz_pkg::ROW_W-1:0]   zone_actual_nonzeros,
  output logic [prz_pkg::PSUM_W-1:0]  zone_padded_nonzeros,
  output logic [prz_pkg::LANE_W-1:0]  lane_nonzeros,
  output logic [prz_pkg::ZTGT_W-1:0]  zone_target
);
  import prz_pkg::*;

  logic [ROW_W-1:0]  row_index;
  logic [ROW_W-1:0]  zone_origin;
  logic [PSUM_W-1:0] padded_sum;
  logic [ROW_W-1:0]  actual_sum;
  logic              out_valid;
  logic [PSUM_W:0]   psum_wide;
  logic [PSUM_W-1:0] psum;
  logic [ROW_W:0]    asum_wide;
  logic [ROW_W-1:0]  asum;
  logic              is_last;
  logic              close;
  logic [ROW_W-1:0]  row_inc;

  assign q_pop = q_valid && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    psum_wide = {1'b0, padded_sum} + {1'b0, q_head.padded};
    psum      = psum_wide[PSUM_W] ? '1 : psum_wide[PSUM_W-1:0];
    asum_wide = {1'b0, actual_sum} + {1'b0, q_head.raw};
    asum      = asum_wide[ROW_W] ? '1 : asum_wide[ROW_W-1:0];
    is_last   = (row_index == info.last_row);
    close     = (psum >= PSUM_W'(info.target)) || is_last;
    row_inc   = row_index + ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index   <= '0;
      zone_origin <= '0;
      padded_sum  <= '0;
      actual_sum  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) out_valid <= 1'b0;
      if (q_pop) begin
        if (close) begin
          out_valid  <= 1'b1;
          padded_sum <= '0;
          actual_sum <= '0;
          if (is_last) begin
            row_index   <= '0;
            zone_origin <= '0;
          end else begin
            row_index   <= row_inc;
            zone_origin <= row_inc;
          end
        end else begin
          padded_sum <= psum;
          actual_sum <= asum;
          row_index  <= row_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && close) begin
      zone_first_row       <= zone_origin;
      zone_last_row        <= row_index;
      zone_rows            <= row_index - zone_origin + ROW_W'(1);
      zone_actual_nonzeros <= asum;
      zone_padded_nonzeros <= psum;
      lane_nonzeros        <= info.lane;
      zone_target          <= info.target[ZTGT_W-1:0];
    end
  end

endmodule

FILE: rtl/padded_row_zone_builder_top.sv
// Top level of the padded row zone builder.
`timescale 1ns / 1ps
// Groups consecutive sparse-matrix rows into zones of padded work.
// Input channel: push / full, one row nonzero count per beat, rows in order.
// Result channel: empty / pop; a beat is one closed zone (first and last row,
//   row count, raw and padded nonzero sums, lane width and zone target).
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   total_nonzeros (0) or row_count (1); other indexes are ignored. Write only
//   while no rows are in flight. A write holds full high while the lane
//   width is re-derived from the new values.
// Throughput: one row per cycle sustained while results are popped; the back
//   end accumulator takes one rounded row per cycle while no result waits.
// Path: a row that closes a zone passes the first and second rounding stages
//   and a queue write, then its result lands in the result register.
// Reset (rst, synchronous): sums and row index clear, registers return to
//   total_nonzeros = 0 and row_count = 1, and full is held high after it.
// Stall: while a result waits on pop, the back end stops, the queue fills,
//   then the rounding stages hold and full rises; nothing is dropped.
module padded_row_zone_builder_top #(
  parameter int ZONE_BLOCK  = prz_pkg::ZONE_BLOCK_DEFAULT,
  parameter int QUEUE_DEPTH = prz_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [prz_pkg::ROW_W-1:0]        row_nonzeros,
  output logic                             empty,
  input  logic                             pop,
  output logic [prz_pkg::ROW_W-1:0]        zone_first_row,
  output logic [prz_pkg::ROW_W-1:0]        zone_last_row,
  output logic [prz_pkg::ROW_W-1:0]        zone_rows,
  output logic [prz_pkg::ROW_W-1:0]        zone_actual_nonzeros,
  output logic [prz_pkg::PSUM_W-1:0]       zone_padded_nonzeros,
  output logic [prz_pkg::LANE_W-1:0]       lane_nonzeros,
  output logic [prz_pkg::ZTGT_W-1:0]       zone_target,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prz_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prz_pkg::ROW_W-1:0]        cfg_data
);
  import prz_pkg::*;

  lane_info_t info;
  logic       fq_push;
  row_item_t  fq_item;
  logic       fq_full;
  logic       bq_pop;
  row_item_t  bq_head;
  logic       bq_valid;

  assign cfg_ready = 1'b1;

  // config registers and lane width, target and last row
  prz_lane #(
    .ZONE_BLOCK (ZONE_BLOCK)
  ) u_lane (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .info      (info)
  );

  // input beats, rounding to lane width
  prz_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .row_nonzeros (row_nonzeros),
    .info         (info),
    .q_push       (fq_push),
    .q_item       (fq_item),
    .q_full       (fq_full)
  );

  // decoupling queue
  prz_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (fq_full),
    .pop       (bq_pop),
    .head      (bq_head),
    .valid     (bq_valid)
  );

  // accumulation and zone close
  prz_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_valid              (bq_valid),
    .q_head               (bq_head),
    .q_pop                (bq_pop),
    .info                 (info),
    .empty                (empty),
    .pop                  (pop),
    .zone_first_row       (zone_first_row),
    .zone_last_row        (zone_last_row),
    .zone_rows            (zone_rows),
    .zone_actual_nonzeros (zone_actual_nonzeros),
    .zone_padded_nonzeros (zone_padded_nonzeros),
    .lane_nonzeros        (lane_nonzeros),
    .zone_target          (zone_target)
  );

endmodule

FILE: rtl/prz_checker.sv
// Port-level checker of the padded row zone builder and its bind.
`timescale 1ns / 1ps
`include "padded_row_zone_builder_top_macros.svh"
module prz_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             full,
  input logic                             empty,
  input logic                             pop,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [prz_pkg::ROW_W-1:0]        zone_first_row,
  input logic [prz_pkg::ROW_W-1:0]        zone_last_row,
  input logic [prz_pkg::ROW_W-1:0]        zone_rows,
  input logic [prz_pkg::LANE_W-1:0]       lane_nonzeros
);
  import prz_pkg::*;

  // reset leaves no result and blocks input while lane width settles
  `PRZ_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, empty && full)
  // a register write blocks input for the re-derivation
  `PRZ_ASSERT_NEXT(a_cfg_blocks, clk, rst, cfg_valid && cfg_ready, full)
  // row count agrees with the row range
  `PRZ_ASSERT_NOW(a_rows_match, clk, rst, !empty,
                  zone_rows == ROW_W'(zone_last_row - zone_first_row + ROW_W'(1)))
  // lane width stays within one to five
  `PRZ_ASSERT_NOW(a_lane_range, clk, rst, !empty,
                  (lane_nonzeros >= LANE_1) && (lane_nonzeros <= LANE_5))
  // a waiting result holds
  `PRZ_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop,
                   !empty && $stable(zone_first_row) && $stable(zone_last_row))

endmodule

bind padded_row_zone_builder_top prz_checker u_prz_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .zone_first_row (zone_first_row),
  .zone_last_row  (zone_last_row),
  .zone_rows      (zone_rows),
  .lane_nonzeros  (lane_nonzeros)
);

FILE: verif/tb_padded_row_zone_builder_top.sv
// Self-checking testbench of the padded row zone builder top level.
`timescale 1ns / 1ps
module tb_padded_row_zone_builder_top;
  import prz_pkg::*;

  // Rows accepted before the quiet tail (no idling on either side) begins.
  localparam int QUIET_FROM = 850;
  localparam int ROW_GOAL = 1050;
  localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};
  // Indexes the block decodes to nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]  first_row;
    logic [ROW_W-1:0]  last_row;
    logic [ROW_W-1:0]  rows;
    logic [ROW_W-1:0]  actual;
    logic [PSUM_W-1:0] padded;
    logic [LANE_W-1:0] lane;
    logic [ZTGT_W-1:0] target;
  } zone_t;

  // Tracks the zone grouping of the row stream and holds the zones still owed.
  class zone_scoreboard;
    logic [ROW_W-1:0] total_nz;
    logic [ROW_W-1:0] row_cnt;
    logic [ROW_W-1:0] row_idx;
    logic [ROW_W-1:0] zone_origin;
    longint unsigned  padded_sum;
    longint unsigned  actual_sum;
    zone_t            owed_zones[$];
    int               errors;
    int               zones_seen;
    int               rows_seen;
    int               writes_seen;
    logic [5:1]       lanes_seen;

    function new();
      total_nz    = '0;
      row_cnt     = ROW_W'(1);
      row_idx     = '0;
      zone_origin = '0;
      padded_sum  = 0;
      actual_sum  = 0;
      errors      = 0;
      zones_seen  = 0;
      rows_seen   = 0;
      writes_seen = 0;
      lanes_seen  = '0;
    endfunction

    function int pending();
      return owed_zones.size();
    endfunction

    // Exact mean thresholds: round-half below 3, round up from .1 at 3 and above.
    function logic [LANE_W-1:0] lane_width();
      longint unsigned t;
      longint unsigned m;
      t = total_nz;
      m = row_cnt;
      if (t < m || 2 * t < 3 * m) return LANE_1;
      if (2 * t < 5 * m) return LANE_2;
      if (t < 3 * m || 10 * t < 31 * m) return LANE_3;
      if (10 * t < 41 * m) return LANE_4;
      return LANE_5;
    endfunction

    function void note_write(logic [CFG_INDEX_W-1:0] idx, logic [ROW_W-1:0] data);
      writes_seen++;
      if (idx == REG_TOTAL_NONZEROS) total_nz = data;
      else if (idx == REG_ROW_COUNT) row_cnt = data;
    endfunction

    function void note_row(logic [ROW_W-1:0] r);
      logic [LANE_W-1:0] lane;
      longint unsigned   lw;
      longint unsigned   target;
      longint unsigned   padded;
      logic [ROW_W-1:0]  last;
      logic              matrix_end;
      zone_t             z;
      lane   = lane_width();
      lw     = lane;
      target = lw * ZONE_BLOCK_DEFAULT;
      padded = ((r + lw - 1) / lw) * lw;
      last   = row_cnt - 1'b1;
      rows_seen++;
      lanes_seen[lane] = 1'b1;
      padded_sum += padded;
      if (padded_sum > 64'hFFFF_FFFF) padded_sum = 64'hFFFF_FFFF;
      actual_sum += r;
      if (actual_sum > 64'h7FFF_FFFF) actual_sum = 64'h7FFF_FFFF;
      matrix_end = (row_idx == last);
      if (padded_sum >= target || matrix_end) begin
        z.first_row = zone_origin;
        z.last_row  = row_idx;
        z.rows      = row_idx - zone_origin + 1'b1;
        z.actual    = actual_sum[ROW_W-1:0];
        z.padded    = padded_sum[PSUM_W-1:0];
        z.lane      = lane;
        z.target    = target[ZTGT_W-1:0];
        owed_zones.push_back(z);
        padded_sum = 0;
        actual_sum = 0;
        if (matrix_end) begin
          row_idx     = '0;
          zone_origin = '0;
        end else begin
          row_idx     = row_idx + 1'b1;
          zone_origin = row_idx;
        end
      end else begin
        row_idx = row_idx + 1'b1;
      end
    endfunction

    function void check_zone(zone_t got);
      zone_t want;
      string bad;
      zones_seen++;
      if (owed_zones.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected zone beat first=%0d last=%0d rows=%0d",
                   got.first_row, got.last_row, got.rows);
        return;
      end
      want = owed_zones.pop_front();
      bad = "";
      if (got.first_row !== want.first_row) bad = {bad, " first_row"};
      if (got.last_row  !== want.last_row)  bad = {bad, " last_row"};
      if (got.rows      !== want.rows)      bad = {bad, " rows"};
      if (got.actual    !== want.actual)    bad = {bad, " actual"};
      if (got.padded    !== want.padded)    bad = {bad, " padded"};
      if (got.lane      !== want.lane)      bad = {bad, " lane"};
      if (got.target    !== want.target)    bad = {bad, " target"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: zone mismatch in%s", bad);
          $display("  exp first=%0d last=%0d rows=%0d actual=%0d padded=%0d lane=%0d tgt=%0d",
                   want.first_row, want.last_row, want.rows, want.actual, want.padded,
                   want.lane, want.target);
          $display("  got first=%0d last=%0d rows=%0d actual=%0d padded=%0d lane=%0d tgt=%0d",
                   got.first_row, got.last_row, got.rows, got.actual, got.padded,
                   got.lane, got.target);
        end
      end
    endfunction

    function void report_leftovers();
      if (owed_zones.size() != 0) begin
        $display("ERROR: %0d zones never came out", owed_zones.size());
        errors += owed_zones.size();
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic [ROW_W-1:0]       row_nonzeros;
  logic                   empty;
  logic                   pop;
  logic [ROW_W-1:0]       zone_first_row;
  logic [ROW_W-1:0]       zone_last_row;
  logic [ROW_W-1:0]       zone_rows;
  logic [ROW_W-1:0]       zone_actual_nonzeros;
  logic [PSUM_W-1:0]      zone_padded_nonzeros;
  logic [LANE_W-1:0]      lane_nonzeros;
  logic [ZTGT_W-1:0]      zone_target;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [ROW_W-1:0]       cfg_data;

  zone_scoreboard sb;
  int             rows_fed = 0;

  padded_row_zone_builder_top dut (
    .clk                  (clk),
    .rst                  (rst),
    .push                 (push),
    .full                 (full),
    .row_nonzeros         (row_nonzeros),
    .empty                (empty),
    .pop                  (pop),
    .zone_first_row       (zone_first_row),
    .zone_last_row        (zone_last_row),
    .zone_rows            (zone_rows),
    .zone_actual_nonzeros (zone_actual_nonzeros),
    .zone_padded_nonzeros (zone_padded_nonzeros),
    .lane_nonzeros        (lane_nonzeros),
    .zone_target          (zone_target),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog well past the slowest legal run (every row a zone, every gap
  // and stall at its longest, reprogram pauses).
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Sample every handshake with pre-edge values; drivers only change on NBAs.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.note_write(cfg_index, cfg_data);
      if (pop && !empty)
        sb.check_zone('{zone_first_row, zone_last_row, zone_rows, zone_actual_nonzeros,
                        zone_padded_nonzeros, lane_nonzeros, zone_target});
      if (push && !full) sb.note_row(row_nonzeros);
    end
  end

  // Result side: pop mostly high, random stall bursts until the quiet tail.
  initial begin
    pop <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (rows_fed < QUIET_FROM && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  // One row beat; push stays up for a following beat unless a gap is drawn.
  task automatic feed_row(input logic [ROW_W-1:0] v);
    row_nonzeros <= v;
    push         <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    rows_fed++;
    if (rows_fed < QUIET_FROM && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Leaves cfg_valid high so back-to-back writes need no extra toggle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [ROW_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Rows that close no zone may still sit in the rounding stages, so let
  // the pipe drain past the last owed zone before touching registers.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_matrix(input logic [ROW_W-1:0] t, input logic [ROW_W-1:0] m);
    wait_idle();
    write_reg(REG_TOTAL_NONZEROS, t);
    write_reg(REG_ROW_COUNT, m);
    cfg_valid <= 1'b0;
  endtask

  // Mostly row sizes that close zones every few beats, some full-range noise.
  function automatic logic [ROW_W-1:0] pick_row();
    logic [ROW_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = ROW_W'($urandom_range(0, 160));
      6, 7:             v = ROW_W'($urandom_range(0, 8));
      8:                v = ROW_W'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = ROW_MAX;
          2:       v = ROW_W'(127);
          3:       v = ROW_W'(128);
          4:       v = ROW_W'(639);
          default: v = ROW_W'(640);
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int               k;
    int               n;
    int               pick;
    logic [ROW_W-1:0] base;
    logic [ROW_W-1:0] m_new;
    logic [ROW_W-1:0] t_new;
    longint unsigned  t64;
    int               mean_x10[8];
    mean_x10 = '{14, 15, 24, 25, 30, 31, 40, 41};
    sb = new();
    rst          <= 1'b1;
    push         <= 1'b0;
    row_nonzeros <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_TOTAL_NONZEROS;
    cfg_data     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: one-row matrix, so every row is its own zone.
    feed_row('0);
    feed_row(ROW_W'(1));
    feed_row(ROW_MAX);
    feed_row(ROW_W'(32'h5555_5555));
    feed_row(ROW_W'(32'h2AAA_AAAA));

    // Lane 2, target 256; the row of 255 here crosses the target.
    set_matrix(ROW_W'(15), ROW_W'(10));
    feed_row('0);
    feed_row(ROW_W'(1));
    feed_row(ROW_W'(3));
    feed_row(ROW_W'(255));
    feed_row('0);

    // Writes to undecoded indexes must leave the registers alone.
    wait_idle();
    write_reg(REG_UNUSED_2, ROW_MAX);
    write_reg(REG_UNUSED_3, '0);
    cfg_valid <= 1'b0;

    // Zero rows: lane 5 and a last row that is never reached.
    set_matrix(ROW_W'(7), '0);
    feed_row(ROW_W'(639));
    feed_row(ROW_W'(1));
    feed_row(ROW_MAX);

    // Row count dropped below the running index: index just keeps counting.
    set_matrix('0, ROW_W'(2));
    feed_row(ROW_W'(100));
    feed_row(ROW_W'(100));

    // Walk the lane boundaries of the mean, scaled up past the row index.
    for (k = 0; k < 8; k++) begin
      base = ROW_W'((sb.row_idx / 10 + 2) * 10);
      set_matrix(ROW_W'((base / 10) * mean_x10[k]), base);
      feed_row(ROW_W'(7));
    end

    // Random phases: reprogram while idle, then a burst of rows.
    while (rows_fed < ROW_GOAL) begin
      pick  = $urandom_range(0, 9);
      m_new = ROW_W'(sb.row_idx + 1 + $urandom_range(0, 60));
      case (pick)
        0: set_matrix(ROW_W'($urandom), '0);
        1: begin
          t_new = $urandom_range(0, 1) ? ROW_MAX : ROW_W'($urandom);
          set_matrix(t_new, ROW_MAX);
        end
        2: set_matrix(ROW_MAX, m_new);
        3: begin
          wait_idle();
          write_reg(REG_TOTAL_NONZEROS, ROW_W'($urandom_range(0, 400)));
          cfg_valid <= 1'b0;
        end
        4: begin
          if (sb.row_idx > 1)
            set_matrix(ROW_W'($urandom_range(0, 40)),
                       ROW_W'($urandom_range(1, sb.row_idx - 1)));
          else
            set_matrix('0, m_new);
        end
        5: begin
          wait_idle();
          write_reg(REG_UNUSED_3, ROW_W'($urandom));
          write_reg(REG_UNUSED_2, ROW_W'($urandom));
          cfg_valid <= 1'b0;
        end
        default: begin
          t64 = longint'(m_new) * $urandom_range(0, 5) + $urandom_range(0, m_new);
          set_matrix(t64[ROW_W-1:0], m_new);
        end
      endcase
      n = $urandom_range(10, 60);
      repeat (n) feed_row(pick_row());
    end

    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    sb.report_leftovers();

    $display("Run covered %0d row beats and %0d zone beats across %0d register writes.",
             sb.rows_seen, sb.zones_seen, sb.writes_seen);
    $display("Lane widths hit (bit n = width n): %b, mismatches: %0d",
             sb.lanes_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
